// ===== sv/sjl_pkg.sv =====
// ----------------------------------------------------------------------------
// sjl_pkg
// Shared types and constants for the self-organizing map winner lookup:
// payload structs, table geometry, joint limits and quantization constants.
// ----------------------------------------------------------------------------
package sjl_pkg;

  localparam int MAX_CELLS  = 8;
  localparam int MAX_PROTOS = 16;
  localparam int JOINTS     = 4;

  localparam int AXIS_BITS  = $clog2(MAX_CELLS);
  localparam int CELL_BITS  = 3 * AXIS_BITS;
  localparam int PROTO_BITS = $clog2(MAX_PROTOS);
  localparam int JOINT_BITS = $clog2(JOINTS);
  localparam int ROW_BITS   = CELL_BITS + PROTO_BITS;
  localparam int ROW_DEPTH  = 2 ** ROW_BITS;

  // 90 degrees in 1/64 degree units
  localparam int SPAN_RAW = 5760;

  localparam logic [3:0] MAX_CELLS_N = 4'(MAX_CELLS);
  localparam logic [4:0] MAX_PROTOS_N = 5'(MAX_PROTOS);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] CFG_CELLS_Y    = 3'd0;
  localparam logic [2:0] CFG_CELLS_P    = 3'd1;
  localparam logic [2:0] CFG_CELLS_V    = 3'd2;
  localparam logic [2:0] CFG_PROTOS     = 3'd3;

  // axis minima: az -80, el -60, ver 0 degrees
  localparam logic signed [16:0] AXIS_MIN [3] = '{-17'sd5120, -17'sd3840, 17'sd0};

  // joint limits, inclusive
  localparam logic signed [15:0] JOINT_LOW  [JOINTS] =
    '{-16'sd3840, 16'sd0, -16'sd2240, 16'sd640};
  localparam logic signed [15:0] JOINT_HIGH [JOINTS] =
    '{16'sd0, 16'sd6400, 16'sd3840, 16'sd6400};

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FAULT = 2'd1,
    STATUS_RANGE = 2'd2
  } sjl_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUANT,
    ST_SEARCH,
    ST_WAIT,
    ST_CHECK
  } sjl_state_t;

  typedef logic [JOINTS-1:0][15:0] sjl_joints_t;

  typedef struct packed {
    logic                    operation;
    logic [8:0]              load_cell;
    logic [3:0]              load_proto;
    logic [1:0]              load_joint;
    logic signed [15:0]      load_value;
    logic signed [15:0]      target_az;
    logic signed [15:0]      target_el;
    logic signed [15:0]      target_ver;
    logic signed [15:0]      pos_0;
    logic signed [15:0]      pos_1;
    logic signed [15:0]      pos_2;
    logic signed [15:0]      pos_3;
  } sjl_in_t;

  typedef struct packed {
    sjl_status_t             status;
    logic [3:0]              prototype_index;
    logic signed [15:0]      joint_cmd_0;
    logic signed [15:0]      joint_cmd_1;
    logic signed [15:0]      joint_cmd_2;
    logic signed [15:0]      joint_cmd_3;
  } sjl_out_t;

  typedef struct packed {
    logic [3:0] cells_y;
    logic [3:0] cells_p;
    logic [3:0] cells_v;
    logic [4:0] prototypes_used;
  } sjl_cfg_t;

  // one prototype read issued to the distance unit
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [PROTO_BITS-1:0] idx;
  } sjl_issue_t;

  typedef struct packed {
    logic                 out_of_range;
    logic [CELL_BITS-1:0] cell_idx;
  } sjl_quant_t;

endpackage

// ===== sv/som_winner_joint_lookup.sv =====
// ----------------------------------------------------------------------------
// som_winner_joint_lookup
// Best-matching-unit lookup in a self-organizing visuomotor map. Loads write
// single weight words; a query quantizes the target to a cell, finds the
// nearest prototype of that cell and checks it against the joint limits.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid, in_stall  | in_data  (sjl_in_t)
//  out     | out_valid, out_stall| out_data (sjl_out_t)
//  cfg     | cfg_valid, cfg_ready| cfg_index, cfg_data
//
//  a load is written at the edge that accepts it
//  a query steps through the quant, search, wait and check states and searches
//  1 to 16 prototypes; an out-of-range cell goes from quant straight to check; the distance unit
//  handles one prototype per cycle, four joint words read in parallel from
//  four memories
//  in_stall stays high while a query is in progress
//  rst is synchronous; the weight memories are not cleared
//  a finished result waits in the output register while the next item enters
//
module som_winner_joint_lookup (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sjl_pkg::sjl_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sjl_pkg::sjl_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_data
);
  import sjl_pkg::*;

  sjl_state_t            state;
  sjl_state_t            state_next;
  sjl_cfg_t              cfg;
  sjl_in_t               item;
  sjl_quant_t            quant;
  logic [CELL_BITS-1:0]  cell_idx;
  logic                  range_err;
  logic [PROTO_BITS-1:0] k;
  logic [PROTO_BITS-1:0] k_last;
  logic [PROTO_BITS-1:0] k_last_next;
  logic                  in_accept;
  logic                  load_result;
  sjl_issue_t            issue;
  sjl_joints_t           pos;
  sjl_joints_t           ram_q;
  logic [PROTO_BITS-1:0] best_idx;
  sjl_joints_t           best_w;
  logic                  done;
  logic                  fault;
  sjl_out_t              result;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state == ST_IDLE);

  // ---------------- weight memories, one per joint ----------------
  genvar g;
  generate
    for (g = 0; g < JOINTS; g++) begin : g_ram
      sjl_ram #(
        .WIDTH (16),
        .DEPTH (ROW_DEPTH)
      ) u_ram (
        .clk   (clk),
        .we    (in_accept && in_data.operation == OP_LOAD &&
                in_data.load_joint == JOINT_BITS'(g)),
        .waddr ({in_data.load_cell, in_data.load_proto}),
        .wdata (in_data.load_value),
        .raddr ({cell_idx, k}),
        .rdata (ram_q[g])
      );
    end
  endgenerate

  sjl_quant u_quant (
    .target_az  (item.target_az),
    .target_el  (item.target_el),
    .target_ver (item.target_ver),
    .cfg        (cfg),
    .quant      (quant)
  );

  assign pos = {item.pos_3, item.pos_2, item.pos_1, item.pos_0};

  sjl_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .pos      (pos),
    .weights  (ram_q),
    .best_idx (best_idx),
    .best_w   (best_w),
    .done     (done)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    load_result = 1'b0;
    issue.valid = 1'b0;
    issue.last  = (k == k_last);
    issue.idx   = k;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.operation == OP_QUERY) begin
          state_next = ST_QUANT;
        end
      end
      ST_QUANT: begin
        state_next = quant.out_of_range ? ST_CHECK : ST_SEARCH;
      end
      ST_SEARCH: begin
        issue.valid = 1'b1;
        if (k == k_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!out_valid || !out_stall) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // prototype count: zero acts as one, clamp at the table size
  always_comb begin
    if (cfg.prototypes_used == '0) begin
      k_last_next = '0;
    end else if (cfg.prototypes_used > MAX_PROTOS_N) begin
      k_last_next = PROTO_BITS'(MAX_PROTOS - 1);
    end else begin
      k_last_next = PROTO_BITS'(cfg.prototypes_used - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item   <= in_data;
      k      <= '0;
      k_last <= k_last_next;
    end else if (state == ST_SEARCH) begin
      k <= k + 1'b1;
    end
    if (state == ST_QUANT) begin
      cell_idx  <= quant.cell_idx;
      range_err <= quant.out_of_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_y         <= 4'd8;
      cfg.cells_p         <= 4'd8;
      cfg.cells_v         <= 4'd8;
      cfg.prototypes_used <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELLS_Y: cfg.cells_y         <= cfg_data[3:0];
        CFG_CELLS_P: cfg.cells_p         <= cfg_data[3:0];
        CFG_CELLS_V: cfg.cells_v         <= cfg_data[3:0];
        CFG_PROTOS:  cfg.prototypes_used <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------- limit check and result ----------------
  always_comb begin
    fault = 1'b0;
    for (int j = 0; j < JOINTS; j++) begin
      if ($signed(best_w[j]) < JOINT_LOW[j] || $signed(best_w[j]) > JOINT_HIGH[j]) begin
        fault = 1'b1;
      end
    end
    result = '0;
    if (range_err) begin
      result.status = STATUS_RANGE;
    end else if (fault) begin
      result.status          = STATUS_FAULT;
      result.prototype_index = best_idx;
    end else begin
      result.status          = STATUS_OK;
      result.prototype_index = best_idx;
      result.joint_cmd_0     = best_w[0];
      result.joint_cmd_1     = best_w[1];
      result.joint_cmd_2     = best_w[2];
      result.joint_cmd_3     = best_w[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_data <= result;
    end
  end

  // ---------------- assertions ----------------
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.operation == OP_LOAD |=> state == ST_IDLE)
    else $error("load item left the idle state");

  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CHECK)
    else $error("result appeared outside the check step");

  a_bad_status_zero_joints: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |->
      out_data.joint_cmd_0 == '0 && out_data.joint_cmd_1 == '0 &&
      out_data.joint_cmd_2 == '0 && out_data.joint_cmd_3 == '0)
    else $error("joints driven on a failed query");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_WAIT)
    else $error("distance unit finished outside the wait step");

  a_search_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> k <= k_last)
    else $error("prototype counter ran past the last prototype");

endmodule

// ===== sv/sjl_ram.sv =====
// ----------------------------------------------------------------------------
// sjl_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module sjl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sjl_quant.sv =====
// ----------------------------------------------------------------------------
// sjl_quant
// Quantizes target azimuth, elevation and vergence to a map cell and flags
// cells outside the configured grid.
// ----------------------------------------------------------------------------
module sjl_quant (
  input  logic signed [15:0] target_az,
  input  logic signed [15:0] target_el,
  input  logic signed [15:0] target_ver,
  input  sjl_pkg::sjl_cfg_t  cfg,
  output sjl_pkg::sjl_quant_t quant
);
  import sjl_pkg::*;

  logic [3:0]        n_axis [3];
  logic signed [15:0] raw   [3];
  logic signed [16:0] rel   [3];
  logic signed [21:0] num   [3];
  logic [3:0]        q      [3];
  logic              bad    [3];

  always_comb begin
    n_axis[0] = (cfg.cells_y > MAX_CELLS_N) ? MAX_CELLS_N : cfg.cells_y;
    n_axis[1] = (cfg.cells_p > MAX_CELLS_N) ? MAX_CELLS_N : cfg.cells_p;
    n_axis[2] = (cfg.cells_v > MAX_CELLS_N) ? MAX_CELLS_N : cfg.cells_v;
    raw[0] = target_az;
    raw[1] = target_el;
    raw[2] = target_ver;
    for (int a = 0; a < 3; a++) begin
      rel[a] = $signed({raw[a][15], raw[a]}) - AXIS_MIN[a];
      // vergence count sets the resolution of every axis
      num[a] = rel[a] * $signed({1'b0, n_axis[2]});
      q[a] = '0;
      // floor division by 90 degrees as a threshold ladder
      for (int t = 1; t <= MAX_CELLS; t++) begin
        if (num[a] >= $signed(22'(t * SPAN_RAW))) begin
          q[a] = 4'(t);
        end
      end
      bad[a] = num[a][21] || (q[a] >= n_axis[a]);
    end
    quant.out_of_range = bad[0] || bad[1] || bad[2];
    quant.cell_idx = {q[0][AXIS_BITS-1:0], q[1][AXIS_BITS-1:0], q[2][AXIS_BITS-1:0]};
  end

endmodule

// ===== sv/sjl_dist.sv =====
// ----------------------------------------------------------------------------
// sjl_dist
// Shared squared-distance unit: takes one prototype per cycle from the
// weight memories, squares the joint differences, sums them and keeps the
// nearest prototype seen so far.
// ----------------------------------------------------------------------------
module sjl_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  sjl_pkg::sjl_issue_t                 issue,
  input  sjl_pkg::sjl_joints_t                pos,
  input  sjl_pkg::sjl_joints_t                weights,
  output logic [sjl_pkg::PROTO_BITS-1:0]      best_idx,
  output sjl_pkg::sjl_joints_t                best_w,
  output logic                                done
);
  import sjl_pkg::*;

  sjl_issue_t         s0;
  sjl_issue_t         s1;
  sjl_joints_t        w1;
  logic [31:0]        sq   [JOINTS];
  logic [31:0]        sq_next [JOINTS];
  logic signed [16:0] diff [JOINTS];
  logic signed [33:0] prod [JOINTS];
  logic [33:0]        sum;
  logic [33:0]        best_d;

  // s0 lines up with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s0   <= '0;
      s1   <= '0;
      done <= 1'b0;
    end else begin
      s0   <= issue;
      s1   <= s0;
      done <= s1.valid && s1.last;
    end
  end

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      diff[j] = $signed({pos[j][15], pos[j]}) - $signed({weights[j][15], weights[j]});
      prod[j] = diff[j] * diff[j];
      sq_next[j] = prod[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    w1 <= weights;
    for (int j = 0; j < JOINTS; j++) begin
      sq[j] <= sq_next[j];
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < JOINTS; j++) begin
      sum = sum + {2'b00, sq[j]};
    end
  end

  // first prototype always loads, later ones only when strictly nearer
  always_ff @(posedge clk) begin
    if (s1.valid && (s1.idx == '0 || sum < best_d)) begin
      best_d   <= sum;
      best_idx <= s1.idx;
      best_w   <= w1;
    end
  end

endmodule

// ===== bench/tb_som_winner_joint_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_som_winner_joint_lookup
// Self-checking bench for the map winner lookup. Weight loads are
// mirrored into a local copy of the prototype map. Every query is predicted
// (cell quantization, nearest prototype, joint limit check) and the results
// are compared in order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_som_winner_joint_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import sjl_pkg::*;

  typedef shortint joint_vec_t [4];
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  localparam int SPAN = 5760;
  localparam int AZ_MIN = -5120;
  localparam int EL_MIN = -3840;
  localparam int VER_MIN = 0;
  localparam joint_vec_t JOINT_MIN = '{-3840, 0, -2240, 640};
  localparam joint_vec_t JOINT_MAX = '{0, 6400, 3840, 6400};
  localparam joint_vec_t MID_POSE = '{-1920, 3200, 0, 3200};
  localparam logic [2:0] CFG_INDEX_MAX = 3'd7;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 105;
  localparam int TIMEOUT_NS = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sjl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sjl_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  // mirror of the prototype map and its settings
  shortint map_weights [32768];
  bit map_written [32768];
  logic [3:0] map_cells_y = 4'd8;
  logic [3:0] map_cells_p = 4'd8;
  logic [3:0] map_cells_v = 4'd8;
  logic [4:0] map_protos = 5'd16;
  logic [8:0] trained_cells [$];

  sjl_out_t pending_results [$];
  int mismatch_count = 0;
  int load_count = 0;
  int query_count = 0;
  int status_seen [3] = '{0, 0, 0};
  int config_count = 0;
  int burst_left = 0;
  logic hold_off = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  logic stall_next;

  som_winner_joint_lookup u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_cells(logic [3:0] n);
    return (n > 4'd8) ? 8 : int'(n);
  endfunction

  function automatic int eff_protos();
    if (map_protos == 5'd0) return 1;
    return (map_protos > 5'd16) ? 16 : int'(map_protos);
  endfunction

  function automatic int word_addr(logic [8:0] cell_id, logic [3:0] proto, logic [1:0] joint);
    return int'({cell_id, proto, joint});
  endfunction

  function automatic joint_vec_t proto_weights(logic [8:0] cell_id, logic [3:0] proto);
    joint_vec_t w;
    for (int j = 0; j < 4; j++) w[j] = map_weights[word_addr(cell_id, proto, 2'(j))];
    return w;
  endfunction

  // floor((raw - lo) * res / span), rounding toward minus infinity
  function automatic int quantize(shortint raw, int lo, int res);
    int num;
    num = (int'(raw) - lo) * res;
    if (num >= 0) return num / SPAN;
    return -((-num + SPAN - 1) / SPAN);
  endfunction

  function automatic bit locate_cell(sjl_in_t q, output logic [8:0] cell_id);
    int nv, qy, qp, qv;
    nv = eff_cells(map_cells_v);
    qy = quantize(q.target_az, AZ_MIN, nv);
    qp = quantize(q.target_el, EL_MIN, nv);
    qv = quantize(q.target_ver, VER_MIN, nv);
    cell_id = {qy[2:0], qp[2:0], qv[2:0]};
    return qy >= 0 && qp >= 0 && qv >= 0 && qy < eff_cells(map_cells_y)
      && qp < eff_cells(map_cells_p) && qv < nv;
  endfunction

  function automatic bit cell_ready(logic [8:0] cell_id);
    for (int k = 0; k < eff_protos(); k++)
      for (int j = 0; j < 4; j++)
        if (!map_written[word_addr(cell_id, 4'(k), 2'(j))]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit cell_fits(logic [8:0] cell_id);
    int nv;
    nv = eff_cells(map_cells_v);
    return cell_id[8:6] < eff_cells(map_cells_y) && cell_id[8:6] < nv
      && cell_id[5:3] < eff_cells(map_cells_p) && cell_id[5:3] < nv && cell_id[2:0] < nv;
  endfunction

  function automatic sjl_out_t nearest_prototype_result(sjl_in_t q);
    sjl_out_t r;
    logic [8:0] cell_id;
    joint_vec_t pos, w;
    longint dist_sq, best_dist, diff;
    int best;
    bit fault;
    r = '0;
    if (!locate_cell(q, cell_id)) begin
      r.status = STATUS_RANGE;
      return r;
    end
    pos = '{q.pos_0, q.pos_1, q.pos_2, q.pos_3};
    best = 0;
    best_dist = 0;
    for (int k = 0; k < eff_protos(); k++) begin
      w = proto_weights(cell_id, 4'(k));
      dist_sq = 0;
      for (int j = 0; j < 4; j++) begin
        diff = longint'(pos[j]) - longint'(w[j]);
        dist_sq += diff * diff;
      end
      // strict compare keeps the lowest index on ties
      if (k == 0 || dist_sq < best_dist) begin
        best = k;
        best_dist = dist_sq;
      end
    end
    w = proto_weights(cell_id, 4'(best));
    fault = 1'b0;
    for (int j = 0; j < 4; j++)
      if (w[j] < JOINT_MIN[j] || w[j] > JOINT_MAX[j]) fault = 1'b1;
    r.prototype_index = 4'(best);
    if (fault) begin
      r.status = STATUS_FAULT;
    end else begin
      r.status = STATUS_OK;
      r.joint_cmd_0 = w[0];
      r.joint_cmd_1 = w[1];
      r.joint_cmd_2 = w[2];
      r.joint_cmd_3 = w[3];
    end
    return r;
  endfunction

  function automatic string result_text(sjl_out_t r);
    return $sformatf("status=%0d proto=%0d joints=%0d %0d %0d %0d", r.status,
      r.prototype_index, r.joint_cmd_0, r.joint_cmd_1, r.joint_cmd_2, r.joint_cmd_3);
  endfunction

  task automatic note_mismatch(string what, sjl_out_t want, sjl_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %s, got %s", $realtime, what, result_text(want),
        result_text(got));
  endtask

  task automatic check_result(sjl_out_t got);
    sjl_out_t want;
    if (pending_results.size() == 0) begin
      note_mismatch("result with nothing pending", '0, got);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.prototype_index !== want.prototype_index
          || got.joint_cmd_0 !== want.joint_cmd_0 || got.joint_cmd_1 !== want.joint_cmd_1
          || got.joint_cmd_2 !== want.joint_cmd_2 || got.joint_cmd_3 !== want.joint_cmd_3)
        note_mismatch("lookup mismatch", want, got);
    end
  endtask

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (out_valid && !out_stall) check_result(out_data);
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3, 0));
      mode_left = $urandom_range(300, 40);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE: stall_next = 1'b0;
      STALL_LIGHT: stall_next = $urandom_range(99, 0) < 30;
      STALL_PERIODIC: stall_next = (mode_left % 3) == 0;
      default: stall_next = $urandom_range(99, 0) < 75;
    endcase
    out_stall <= hold_off || stall_next;
  end

  function automatic sjl_in_t random_item();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(sjl_in_t)-1:0];
  endfunction

  task automatic send_item(sjl_in_t item);
    sjl_out_t want;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (item.operation == OP_QUERY) begin
      want = nearest_prototype_result(item);
      pending_results.push_back(want);
      status_seen[int'(want.status)]++;
      query_count++;
    end else begin
      map_weights[word_addr(item.load_cell, item.load_proto, item.load_joint)] =
        item.load_value;
      map_written[word_addr(item.load_cell, item.load_proto, item.load_joint)] = 1'b1;
      load_count++;
    end
    // bursts of random length, sometimes long ones with no gap at all
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? 80 : $urandom_range(24, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_load(logic [8:0] cell_id, logic [3:0] proto, logic [1:0] joint,
                           shortint value);
    sjl_in_t it;
    it = random_item();
    it.operation = OP_LOAD;
    it.load_cell = cell_id;
    it.load_proto = proto;
    it.load_joint = joint;
    it.load_value = value;
    send_item(it);
  endtask

  task automatic send_query(shortint az, shortint el, shortint ver, joint_vec_t pos);
    sjl_in_t it;
    logic [8:0] cell_id;
    it = random_item();
    it.operation = OP_QUERY;
    it.target_az = az;
    it.target_el = el;
    it.target_ver = ver;
    it.pos_0 = pos[0];
    it.pos_1 = pos[1];
    it.pos_2 = pos[2];
    it.pos_3 = pos[3];
    // never look up a cell whose prototypes were not all loaded
    if (locate_cell(it, cell_id) && !cell_ready(cell_id)) it.target_ver = 16'sh8000;
    send_item(it);
  endtask

  function automatic shortint angle_in_cell(int lo, int q, int nv);
    int first, last;
    first = (q * SPAN + nv - 1) / nv;
    last = ((q + 1) * SPAN + nv - 1) / nv - 1;
    return shortint'(lo + first + int'($urandom_range(last - first, 0)));
  endfunction

  task automatic send_aimed_query(logic [8:0] cell_id, joint_vec_t pos);
    int nv;
    nv = eff_cells(map_cells_v);
    send_query(angle_in_cell(AZ_MIN, cell_id[8:6], nv), angle_in_cell(EL_MIN, cell_id[5:3], nv),
      angle_in_cell(VER_MIN, cell_id[2:0], nv), pos);
  endtask

  function automatic shortint joint_weight(int j);
    int r;
    r = $urandom_range(99, 0);
    if (r < 93)
      return shortint'(int'(JOINT_MIN[j])
        + int'($urandom_range(int'(JOINT_MAX[j]) - int'(JOINT_MIN[j]), 0)));
    if (r < 95) return shortint'(int'(JOINT_MIN[j]) - 1);
    if (r < 97) return shortint'(int'(JOINT_MAX[j]) + 1);
    return shortint'($urandom);
  endfunction

  function automatic bit pick_target_cell(output logic [8:0] cell_id);
    logic [8:0] fits [$];
    cell_id = '0;
    foreach (trained_cells[i]) if (cell_fits(trained_cells[i])) fits.push_back(trained_cells[i]);
    if (fits.size() == 0) return 1'b0;
    cell_id = fits[$urandom_range(fits.size() - 1, 0)];
    return 1'b1;
  endfunction

  task automatic drain_and_settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CELLS_Y: map_cells_y = value[3:0];
      CFG_CELLS_P: map_cells_p = value[3:0];
      CFG_CELLS_V: map_cells_v = value[3:0];
      CFG_PROTOS: map_protos = value;
      default: ;
    endcase
  endtask

  // the top data bit of the cell counts is junk and must be dropped
  task automatic program_config(logic [3:0] ny, logic [3:0] np, logic [3:0] nv,
                                logic [4:0] nprot);
    write_reg(CFG_CELLS_Y, {1'($urandom), ny});
    write_reg(CFG_CELLS_P, {1'($urandom), np});
    write_reg(CFG_CELLS_V, {1'($urandom), nv});
    write_reg(CFG_PROTOS, nprot);
    write_reg(3'($urandom_range(CFG_INDEX_MAX, CFG_PROTOS + 3'd1)), 5'($urandom));
    cfg_valid <= 1'b0;
    config_count++;
  endtask

  task automatic random_step();
    int r, a, b;
    logic [8:0] cell_id;
    bit found;
    joint_vec_t pos;
    r = $urandom_range(99, 0);
    found = pick_target_cell(cell_id);
    if (r < 40 && found) begin
      case ($urandom_range(2, 0))
        0: begin
          pos = proto_weights(cell_id, 4'($urandom_range(eff_protos() - 1, 0)));
          for (int j = 0; j < 4; j++) pos[j] = shortint'(pos[j] + $urandom_range(64, 0) - 32);
        end
        1: for (int j = 0; j < 4; j++) pos[j] = joint_weight(j);
        default: for (int j = 0; j < 4; j++) pos[j] = shortint'($urandom);
      endcase
      send_aimed_query(cell_id, pos);
    end else if (r < 50 || (r < 40 && !found)) begin
      for (int j = 0; j < 4; j++) pos[j] = shortint'($urandom);
      send_query(shortint'($urandom), shortint'($urandom), shortint'($urandom), pos);
    end else if (r < 75) begin
      cell_id = trained_cells[$urandom_range(trained_cells.size() - 1, 0)];
      a = $urandom_range(3, 0);
      send_load(cell_id, 4'($urandom), 2'(a), joint_weight(a));
    end else if (r < 85 || !found || eff_protos() < 2) begin
      send_load(9'($urandom), 4'($urandom), 2'($urandom), shortint'($urandom));
    end else begin
      // copy one prototype over a later one, then query right on it
      a = $urandom_range(eff_protos() - 2, 0);
      b = $urandom_range(eff_protos() - 1, a + 1);
      pos = proto_weights(cell_id, 4'(a));
      for (int j = 0; j < 4; j++) send_load(cell_id, 4'(b), 2'(j), pos[j]);
      send_aimed_query(cell_id, pos);
    end
  endtask

  task automatic test_directed_cases();
    joint_vec_t pose;
    drain_and_settle();
    program_config(4'd8, 4'd8, 4'd8, 5'd2);
    // identical prototypes: the lower index wins the tie
    for (int j = 0; j < 4; j++) begin
      send_load(9'd0, 4'd0, 2'(j), MID_POSE[j]);
      send_load(9'd0, 4'd1, 2'(j), MID_POSE[j]);
    end
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN), MID_POSE);
    pose = MID_POSE;
    pose[0] = pose[0] + 20;
    send_load(9'd0, 4'd1, 2'd0, pose[0]);
    send_query(shortint'(AZ_MIN + 719), shortint'(EL_MIN + 719), shortint'(VER_MIN + 719), pose);
    // limits are inclusive, one below faults
    for (int j = 0; j < 4; j++) send_load(9'd0, 4'd0, 2'(j), JOINT_MIN[j]);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN), JOINT_MIN);
    send_load(9'd0, 4'd0, 2'd3, shortint'(int'(JOINT_MIN[3]) - 1));
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN), JOINT_MIN);
    send_load(9'd0, 4'd1, 2'd2, 16'sh7fff);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN),
      '{-32768, -32768, -32768, -32768});
    // just outside the grid on each axis, both sides
    send_query(shortint'(AZ_MIN - 1), shortint'(EL_MIN), shortint'(VER_MIN), MID_POSE);
    send_query(shortint'(AZ_MIN + SPAN), shortint'(EL_MIN), shortint'(VER_MIN), MID_POSE);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN - 1), shortint'(VER_MIN), MID_POSE);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN + SPAN), shortint'(VER_MIN), MID_POSE);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN - 1), MID_POSE);
    send_query(shortint'(AZ_MIN), shortint'(EL_MIN), shortint'(VER_MIN + SPAN), MID_POSE);
    send_query(32767, 32767, 32767, '{32767, 32767, 32767, 32767});
    send_query(-32768, -32768, -32768, '{-32768, -32768, -32768, -32768});
  endtask

  task automatic test_fill_map();
    logic [8:0] cells [8];
    cells = '{{3'd0, 3'd0, 3'd0}, {3'd0, 3'd0, 3'd1}, {3'd1, 3'd0, 3'd0}, {3'd0, 3'd1, 3'd0},
              {3'd1, 3'd1, 3'd1}, {3'd2, 3'd2, 3'd1}, {3'd3, 3'd1, 3'd2}, {3'd7, 3'd7, 3'd7}};
    foreach (cells[i]) begin
      for (int k = 0; k < 16; k++)
        for (int j = 0; j < 4; j++) send_load(cells[i], 4'(k), 2'(j), joint_weight(j));
      trained_cells.push_back(cells[i]);
    end
  endtask

  task automatic test_output_backpressure();
    drain_and_settle();
    program_config(4'd8, 4'd8, 4'd8, 5'd16);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (40) random_step();
    join
  endtask

  task automatic run_phase(logic [3:0] ny, logic [3:0] np, logic [3:0] nv, logic [4:0] nprot);
    drain_and_settle();
    program_config(ny, np, nv, nprot);
    repeat (PHASE_ITEMS) random_step();
  endtask

  task automatic test_config_phases();
    run_phase(4'd8, 4'd8, 4'd8, 5'd16);
    run_phase(4'd1, 4'd1, 4'd1, 5'd1);
    run_phase(4'd2, 4'd2, 4'd2, 5'd0);
    run_phase(4'd15, 4'd15, 4'd15, 5'd31);
    run_phase(4'd8, 4'd3, 4'd4, 5'd5);
    run_phase(4'd0, 4'd8, 4'd8, 5'd16);
    run_phase(4'($urandom), 4'($urandom), 4'($urandom), 5'($urandom));
    run_phase(4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)),
      5'($urandom_range(16, 1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_map();
    test_output_backpressure();
    test_config_phases();
    drain_and_settle();
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("run covered %0d weight loads and %0d queries over %0d register settings",
      load_count, query_count, config_count);
    $display("query outcomes: %0d ok, %0d faulty map, %0d out of range, %0d mismatches",
      status_seen[0], status_seen[1], status_seen[2], mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still pending", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sjl_pkg.sv
sv/sjl_ram.sv
sv/sjl_quant.sv
sv/sjl_dist.sv
sv/som_winner_joint_lookup.sv
bench/tb_som_winner_joint_lookup.sv
